/* rtl/core/circular_deque_macros.svh */
// Assertion macros for the circular deque.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef CIRCULAR_DEQUE_MACROS_SVH
`define CIRCULAR_DEQUE_MACROS_SVH
`ifndef SYNTH
`define CDQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("circular deque assertion failed");
`define CDQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("circular deque assertion failed");
`else
`define CDQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define CDQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/core/cdq_pkg.sv */
// Shared types and constants for the circular deque.
// Used by the controller, the datapath and the top level; depends on nothing.
package cdq_pkg;

    localparam int DEF_DEPTH      = 128;
    localparam int DEF_DATA_WIDTH = 32;

    localparam logic [1:0] REQ_INS_FRONT = 2'd0;
    localparam logic [1:0] REQ_INS_REAR  = 2'd1;
    localparam logic [1:0] REQ_REMOVE    = 2'd2;

    localparam logic [1:0] STS_DONE  = 2'd0;
    localparam logic [1:0] STS_FULL  = 2'd1;
    localparam logic [1:0] STS_EMPTY = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } cdq_state_t;

    typedef struct packed {
        logic accept;
        logic finish;
    } cdq_cmd_t;

    typedef struct packed {
        logic pop_read;
    } cdq_stat_t;

endpackage

/* rtl/core/cdq_ctrl.sv */
// Controller for the circular deque: handshake state machine and result valid.
// Depends on cdq_pkg.
module cdq_ctrl
    import cdq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    input  cdq_stat_t stat,
    output cdq_cmd_t  cmd
);

    cdq_state_t state_reg;
    cdq_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;

    assign in_stall  = (state_reg != ST_IDLE) || (out_valid_reg && out_stall);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && stat.pop_read)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.accept = 1'b0;
        cmd.finish = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = accept;
            end
            ST_READ:
            begin
                cmd.finish = 1'b1;
            end
            default:
            begin
                cmd.accept = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if ((cmd.accept && !stat.pop_read) || cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* rtl/core/cdq_datapath.sv */
// Datapath for the circular deque: pointers, empty mark, entry store, result words.
// Depends on cdq_pkg and circular_deque_macros.svh.
`include "circular_deque_macros.svh"
module cdq_datapath
    import cdq_pkg::*;
#(
    parameter int DEPTH      = DEF_DEPTH,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cdq_cmd_t    cmd,
    output cdq_stat_t   stat,
    input  logic [1:0]  req_type,
    input  logic [31:0] entry_value,
    output logic [1:0]  status,
    output logic [31:0] removed_value,
    output logic        now_empty,
    output logic        now_full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] TOP = AW'(DEPTH - 1);

    logic [DATA_WIDTH-1:0] mem_array [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    logic [AW-1:0] front_reg;
    logic [AW-1:0] front_next;
    logic [AW-1:0] rear_reg;
    logic [AW-1:0] rear_next;
    logic          empty_reg;
    logic          empty_next;

    logic [1:0]    status_reg;
    logic [1:0]    status_next;
    logic [31:0]   removed_reg;
    logic          now_empty_reg;
    logic          now_full_reg;

    logic [AW-1:0] rear_inc;
    logic [AW-1:0] front_inc;
    logic [AW-1:0] front_dec;
    logic [AW-1:0] rear_next_inc;
    logic          full;
    logic          is_insert;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          rd_en;

    logic [DATA_WIDTH+31:0] wr_ext;
    logic [DATA_WIDTH-1:0]  wr_data;
    logic [DATA_WIDTH+31:0] rd_ext;

    assign rear_inc      = (rear_reg == TOP) ? '0 : rear_reg + 1'b1;
    assign front_inc     = (front_reg == TOP) ? '0 : front_reg + 1'b1;
    assign front_dec     = (front_reg == '0) ? TOP : front_reg - 1'b1;
    assign rear_next_inc = (rear_next == TOP) ? '0 : rear_next + 1'b1;
    assign full          = !empty_reg && (rear_inc == front_reg);
    assign is_insert     = (req_type == REQ_INS_FRONT) || (req_type == REQ_INS_REAR);

    assign stat.pop_read = (req_type == REQ_REMOVE) && !empty_reg;
    assign rd_en         = cmd.accept && stat.pop_read;

    assign wr_ext  = {{DATA_WIDTH{1'b0}}, entry_value};
    assign wr_data = wr_ext[DATA_WIDTH-1:0];
    assign rd_ext  = {32'd0, rd_data_reg};

    always_comb
    begin
        front_next  = front_reg;
        rear_next   = rear_reg;
        empty_next  = empty_reg;
        status_next = STS_DONE;
        wr_en       = 1'b0;
        wr_addr     = front_reg;
        unique case (req_type) inside
            REQ_INS_FRONT, REQ_INS_REAR:
            begin
                if (full)
                begin
                    status_next = STS_FULL;
                end
                else if (empty_reg)
                begin
                    front_next = '0;
                    rear_next  = '0;
                    empty_next = 1'b0;
                    wr_en      = 1'b1;
                    wr_addr    = '0;
                end
                else if (req_type == REQ_INS_FRONT)
                begin
                    front_next = front_dec;
                    wr_en      = 1'b1;
                    wr_addr    = front_dec;
                end
                else
                begin
                    rear_next = rear_inc;
                    wr_en     = 1'b1;
                    wr_addr   = rear_inc;
                end
            end
            REQ_REMOVE:
            begin
                if (empty_reg)
                begin
                    status_next = STS_EMPTY;
                end
                else if (front_reg == rear_reg)
                begin
                    front_next = '0;
                    rear_next  = '0;
                    empty_next = 1'b1;
                end
                else
                begin
                    front_next = front_inc;
                end
            end
            default:
            begin
                status_next = STS_DONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            rear_reg  <= '0;
            empty_reg <= 1'b1;
        end
        else if (cmd.accept)
        begin
            front_reg <= front_next;
            rear_reg  <= rear_next;
            empty_reg <= empty_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_array[front_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            status_reg    <= status_next;
            removed_reg   <= '0;
            now_empty_reg <= empty_next;
            now_full_reg  <= !empty_next && (rear_next_inc == front_next);
        end
        else if (cmd.finish)
        begin
            removed_reg <= rd_ext[31:0];
        end
    end

    assign status        = status_reg;
    assign removed_value = removed_reg;
    assign now_empty     = now_empty_reg;
    assign now_full      = now_full_reg;

    `CDQ_ASSERT_IMPL(a_empty_ptrs, clk, rst_n, empty_reg, (front_reg == '0) && (rear_reg == '0))
    `CDQ_ASSERT_IMPL(a_finish_done, clk, rst_n, cmd.finish, status_reg == STS_DONE)
    `CDQ_ASSERT_NEXT(a_full_hold, clk, rst_n, cmd.accept && is_insert && full,
        (front_reg == $past(front_reg)) && (rear_reg == $past(rear_reg)) && !empty_reg)

endmodule

/* rtl/core/circular_deque.sv */
// Circular deque top level: one insert at either end or one front removal per word.
// An insert, the unused code or a rejected request gives its result one cycle after
// acceptance and the next word may be taken in the following cycle; a front removal waits
// for the registered read of the entry store and holds off the next word meanwhile.
// A result held by a stalled receiver stalls the input until that result is taken.
// Reset (rst_n low, asynchronous) empties the deque; store contents are not cleared.
module circular_deque
    import cdq_pkg::*;
#(
    parameter int DEPTH      = DEF_DEPTH,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [31:0] entry_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [31:0] removed_value,
    output logic        now_empty,
    output logic        now_full
);

    cdq_cmd_t  cmd;
    cdq_stat_t stat;

    cdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    cdq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .req_type      (req_type),
        .entry_value   (entry_value),
        .status        (status),
        .removed_value (removed_value),
        .now_empty     (now_empty),
        .now_full      (now_full)
    );

endmodule
